/* rtl/lsc_pkg.sv */
package lsc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUOT_BITS     = 33;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [2:0] CLS_NONE   = 3'd0;
  localparam logic [2:0] CLS_LINE   = 3'd1;
  localparam logic [2:0] CLS_UNIQUE = 3'd2;
  localparam logic [2:0] CLS_XFIXED = 3'd3;
  localparam logic [2:0] CLS_YFIXED = 3'd4;
  localparam logic [2:0] CLS_ANY    = 3'd5;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] rhs_first;
    logic signed [31:0] rhs_second;
  } item_t;

  typedef struct packed {
    logic [2:0]         solution_class;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic        en;
    logic        neg;
    logic [63:0] un;
    logic [63:0] ud;
  } lane_t;

  typedef struct packed {
    logic [2:0] cls;
    lane_t      l0;
    lane_t      l1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/lsc_front.sv */
module lsc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      tol,
  input  logic             item_valid,
  input  lsc_pkg::item_t   item,
  output logic             item_stall,
  input  lsc_pkg::qstat_t  qstat,
  output logic             push,
  output lsc_pkg::entry_t  entry
);
  import lsc_pkg::*;

  logic v1, v2, v3, v4;
  logic front_en;

  logic signed [31:0] c1 [6];
  logic signed [63:0] p_ad, p_bc, p_ed, p_bf, p_af, p_ec;

  logic signed [31:0] c2 [6];
  logic signed [63:0] dd, dx, dy;

  logic [31:0] cm [6];
  logic        cs [6];
  logic        cz [6];
  logic [63:0] md, mx, my;
  logic        sd, sx, sy;
  logic        zd, zx, zy;

  entry_t ent_next;

  assign front_en   = !v4 || !qstat.full;
  assign item_stall = !front_en;
  assign push       = v4 && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (front_en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      c1[0] <= item.coef_a;
      c1[1] <= item.coef_b;
      c1[2] <= item.coef_c;
      c1[3] <= item.coef_d;
      c1[4] <= item.rhs_first;
      c1[5] <= item.rhs_second;
      p_ad  <= 64'(item.coef_a) * 64'(item.coef_d);
      p_bc  <= 64'(item.coef_b) * 64'(item.coef_c);
      p_ed  <= 64'(item.rhs_first) * 64'(item.coef_d);
      p_bf  <= 64'(item.coef_b) * 64'(item.rhs_second);
      p_af  <= 64'(item.coef_a) * 64'(item.rhs_second);
      p_ec  <= 64'(item.rhs_first) * 64'(item.coef_c);

      c2 <= c1;
      dd <= p_ad - p_bc;
      dx <= p_ed - p_bf;
      dy <= p_af - p_ec;

      for (int i = 0; i < 6; i++) begin
        cs[i] <= c2[i][31];
        cm[i] <= c2[i][31] ? 32'(-c2[i]) : c2[i];
        cz[i] <= (c2[i][31] ? 32'(-c2[i]) : c2[i]) <= {16'd0, tol};
      end
      sd <= dd[63];
      sx <= dx[63];
      sy <= dy[63];
      md <= dd[63] ? 64'(-dd) : dd;
      mx <= dx[63] ? 64'(-dx) : dx;
      my <= dy[63] ? 64'(-dy) : dy;
      zd <= (dd[63] ? 64'(-dd) : dd) <= {48'd0, tol};
      zx <= (dx[63] ? 64'(-dx) : dx) <= {48'd0, tol};
      zy <= (dy[63] ? 64'(-dy) : dy) <= {48'd0, tol};

      entry <= ent_next;
    end
  end

  // coefficient slots: 0 a, 1 b, 2 c, 3 d, 4 e, 5 f
  always_comb begin
    ent_next = '0;
    if (!zd) begin
      ent_next.cls = CLS_UNIQUE;
      ent_next.l0  = '{en: 1'b1, neg: sx ^ sd, un: mx, ud: md};
      ent_next.l1  = '{en: 1'b1, neg: sy ^ sd, un: my, ud: md};
    end else if (!zx || !zy) begin
      ent_next.cls = CLS_NONE;
    end else if (cz[0] && cz[1] && cz[2] && cz[3]) begin
      ent_next.cls = (cz[4] && cz[5]) ? CLS_ANY : CLS_NONE;
    end else if (cz[0] && cz[2]) begin
      ent_next.cls = CLS_YFIXED;
      if (!cz[1]) begin
        ent_next.l0 = '{en: 1'b1, neg: cs[4] ^ cs[1], un: 64'(cm[4]), ud: 64'(cm[1])};
      end else begin
        ent_next.l0 = '{en: 1'b1, neg: cs[5] ^ cs[3], un: 64'(cm[5]), ud: 64'(cm[3])};
      end
    end else if (cz[1] && cz[3]) begin
      ent_next.cls = CLS_XFIXED;
      if (!cz[0]) begin
        ent_next.l0 = '{en: 1'b1, neg: cs[4] ^ cs[0], un: 64'(cm[4]), ud: 64'(cm[0])};
      end else begin
        ent_next.l0 = '{en: 1'b1, neg: cs[5] ^ cs[2], un: 64'(cm[5]), ud: 64'(cm[2])};
      end
    end else if (!cz[1]) begin
      ent_next.cls = CLS_LINE;
      ent_next.l0  = '{en: 1'b1, neg: !cs[0] ^ cs[1], un: 64'(cm[0]), ud: 64'(cm[1])};
      ent_next.l1  = '{en: 1'b1, neg: cs[4] ^ cs[1], un: 64'(cm[4]), ud: 64'(cm[1])};
    end else begin
      ent_next.cls = CLS_LINE;
      ent_next.l0  = '{en: 1'b1, neg: !cs[2] ^ cs[3], un: 64'(cm[2]), ud: 64'(cm[3])};
      ent_next.l1  = '{en: 1'b1, neg: cs[5] ^ cs[3], un: 64'(cm[5]), ud: 64'(cm[3])};
    end
  end

endmodule

/* rtl/lsc_queue.sv */
module lsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lsc_pkg::entry_t  din,
  input  logic             pop,
  output lsc_pkg::entry_t  head,
  output lsc_pkg::qstat_t  qstat
);
  import lsc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign qstat.full  = count == CW'(QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* rtl/lsc_div.sv */
module lsc_div #(
  parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  lsc_pkg::lane_t                din,
  output logic [lsc_pkg::QUOT_BITS-1:0] q,
  output logic                          neg,
  output logic                          en,
  output logic                          over
);
  import lsc_pkg::*;

  localparam int QB = QUOT_BITS;
  localparam int RW = 64 + ((FRAC_BITS > QB) ? FRAC_BITS : QB) + 1;

  logic [RW-1:0] rr  [QB];
  logic [63:0]   ud  [QB];
  logic [QB-1:0] qq  [QB+1];
  logic          ng  [QB+1];
  logic          ens [QB+1];
  logic          ov  [QB+1];

  logic [RW-1:0] n0;

  assign n0 = RW'(din.un) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      rr[0]  <= n0;
      ud[0]  <= din.ud;
      qq[0]  <= '0;
      ng[0]  <= din.neg;
      ens[0] <= din.en;
      ov[0]  <= din.en && ((n0 >> QB) >= RW'(din.ud));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(ud[k-1]) << (QB - k);
    assign ge = rr[k-1] >= sh;

    always_ff @(posedge clk) begin
      if (adv) begin
        qq[k]  <= {qq[k-1][QB-2:0], ge};
        ng[k]  <= ng[k-1];
        ens[k] <= ens[k-1];
        ov[k]  <= ov[k-1];
      end
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rr[k] <= ge ? rr[k-1] - sh : rr[k-1];
          ud[k] <= ud[k-1];
        end
      end
    end
  end

  assign q    = qq[QB];
  assign neg  = ng[QB];
  assign en   = ens[QB];
  assign over = ov[QB];

endmodule

/* rtl/lsc_back.sv */
module lsc_back #(
  parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lsc_pkg::entry_t  head,
  input  lsc_pkg::qstat_t  qstat,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output lsc_pkg::result_t result
);
  import lsc_pkg::*;

  localparam int DL = QUOT_BITS + 1;

  logic             adv;
  logic             vl  [DL];
  logic [2:0]       cls [DL];
  logic [QUOT_BITS-1:0] q0, q1;
  logic             n0, n1, e0, e1, o0, o1;
  logic [32:0]      r0, r1;

  function automatic logic [32:0] finish(input logic [QUOT_BITS-1:0] q, input logic neg,
                                         input logic en, input logic over);
    logic [QUOT_BITS-1:0] lim;
    logic [QUOT_BITS-1:0] m;
    logic                 sat;
    logic [31:0]          v;
    lim = neg ? QUOT_BITS'(33'h080000000) : QUOT_BITS'(33'h07FFFFFFF);
    sat = over || (q > lim);
    m   = sat ? lim : q;
    v   = neg ? 32'(-m) : m[31:0];
    return en ? {sat, v} : 33'd0;
  endfunction

  assign adv = !result_valid || !result_stall;
  assign pop = adv && !qstat.empty;

  lsc_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
    .clk(clk), .adv(adv), .din(head.l0), .q(q0), .neg(n0), .en(e0), .over(o0)
  );

  lsc_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
    .clk(clk), .adv(adv), .din(head.l1), .q(q1), .neg(n1), .en(e1), .over(o1)
  );

  assign r0 = finish(q0, n0, e0, o0);
  assign r1 = finish(q1, n1, e1, o1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) begin
        vl[i] <= 1'b0;
      end
      result_valid <= 1'b0;
    end else if (adv) begin
      vl[0] <= !qstat.empty;
      for (int i = 1; i < DL; i++) begin
        vl[i] <= vl[i-1];
      end
      result_valid <= vl[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls[0] <= head.cls;
      for (int i = 1; i < DL; i++) begin
        cls[i] <= cls[i-1];
      end
      result.solution_class <= cls[DL-1];
      result.first_value    <= r0[31:0];
      result.second_value   <= r1[31:0];
      result.saturated      <= r0[32] || r1[32];
    end
  end

endmodule

/* rtl/linear_system_2x2_classifier.sv */
// Solves a*x+b*y=e, c*x+d*y=f (signed Q16.16) by Cramer's rule and reports the
// class of the system with up to two Q values and a saturation flag. One item
// per clock is sustained while result_stall is low. On the way to the result an
// item passes 4 front stages (products, determinants, magnitudes, classification),
// the 4-entry queue, 34 stages of the restoring divider (each but the first
// retires one quotient bit) and the output register. The front keeps accepting
// while results are stalled until the queue fills. zero_tolerance is written
// through the cfg port (always ready) and should change only while idle.
module linear_system_2x2_classifier #(
  parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  lsc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output lsc_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import lsc_pkg::*;

  logic [15:0] zero_tolerance;
  logic        push, pop;
  entry_t      entry, head;
  qstat_t      qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      zero_tolerance <= cfg_data;
    end
  end

  lsc_front u_front (
    .clk(clk), .rst(rst), .tol(zero_tolerance),
    .item_valid(item_valid), .item(item), .item_stall(item_stall),
    .qstat(qstat), .push(push), .entry(entry)
  );

  lsc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(entry),
    .pop(pop), .head(head), .qstat(qstat)
  );

  lsc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .head(head), .qstat(qstat), .pop(pop),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full && !pop))
    else $error("queue overflow");

  a_sat_class: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      result.solution_class != CLS_NONE && result.solution_class != CLS_ANY)
    else $error("saturation without a division");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.solution_class == CLS_NONE
                     || result.solution_class == CLS_ANY) |->
      result.first_value == 0 && result.second_value == 0)
    else $error("values set for a class without values");

  a_single_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.solution_class == CLS_XFIXED
                     || result.solution_class == CLS_YFIXED) |->
      result.second_value == 0)
    else $error("second value set for a single-value class");
`endif

endmodule
